/* sv/sor_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the spiral order readout block.
// No dependencies; used by the top level.
package sor_pkg;

  // Default sizes of the element store
  localparam int MAX_ROWS_DEF   = 64;
  localparam int MAX_COLS_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths of the request and result
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 6;
  localparam int REG_W     = 7;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;

  // Request modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  // Walk direction around the current ring
  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  typedef struct packed {
    logic                      mode;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] elem_value;
    logic [POS_W-1:0]          row_pos;
    logic [POS_W-1:0]          col_pos;
    logic                      is_last;
    logic                      error;
  } resp_t;

endpackage

/* sv/sor_ram.sv */
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data (read-first).
// No dependencies.
module sor_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                        wdata,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read the addressed word every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* sv/spiral_order_readout_top.sv */
`timescale 1ns / 1ps
// Spiral order readout: element store, spiral walker and result register.
// Depends on sor_pkg and sor_ram.

// Load requests write the matrix in row-major order, one element per cycle
// while requests are not stalled. Fetch requests return the elements in
// clockwise spiral order. A fetch that reads the store passes through the
// synchronous read of the element RAM and then the output register; the
// request side is stalled during the read cycle. A refused fetch (load not
// complete, or readout finished) skips the read and places its error result
// in the output register directly. Requests also stall while a result waits
// in the output register and the receiver stalls. The store needs no
// clearing pass after reset; an element that was never loaded is never
// fetched. Writing rows or cols restarts load and readout progress.
module spiral_order_readout_top
  import sor_pkg::*;
#(
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req_data,
  output logic                 resp_valid,
  input  logic                 resp_stall,
  output resp_t                resp_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int RS_W  = $clog2(MAX_ROWS + 1);
  localparam int CS_W  = $clog2(MAX_COLS + 1);
  localparam int RP_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CP_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // Configuration and progress registers
  logic [REG_W-1:0] rows, cols;
  logic [CNT_W-1:0] load_count, emit_count;
  logic [RP_W-1:0]  top_bound, bottom_bound, cur_row;
  logic [CP_W-1:0]  left_bound, right_bound, cur_col;
  logic [AW-1:0]    idx;
  dir_t             direction;
  state_t           state;

  // Held metadata of the fetch whose element is being read
  logic [RP_W-1:0]  pend_row;
  logic [CP_W-1:0]  pend_col;
  logic             pend_last;

  logic [RS_W-1:0]  r_eff;
  logic [CS_W-1:0]  c_eff;
  logic [CNT_W-1:0] total;

  // Clamp the size registers to the supported range
  always_comb begin
    if (rows == '0) begin
      r_eff = RS_W'(1);
    end else if (int'(rows) > MAX_ROWS) begin
      r_eff = RS_W'(MAX_ROWS);
    end else begin
      r_eff = RS_W'(rows);
    end
    if (cols == '0) begin
      c_eff = CS_W'(1);
    end else if (int'(cols) > MAX_COLS) begin
      c_eff = CS_W'(MAX_COLS);
    end else begin
      c_eff = CS_W'(cols);
    end
  end

  assign total = CNT_W'(r_eff) * CNT_W'(c_eff);

  // Request decode
  logic acc, acc_load, acc_fetch, fetch_ok;
  logic [CNT_W-1:0] load_base;
  logic load_ok, done;

  assign acc       = req_valid && !req_stall;
  assign acc_load  = acc && (req_data.mode == MODE_LOAD);
  assign acc_fetch = acc && (req_data.mode == MODE_FETCH);
  assign done      = (emit_count >= total);
  assign load_base = done ? '0 : load_count;
  assign load_ok   = (load_base < total);
  assign fetch_ok  = (load_count >= total) && !done;

  // Present position: the first fetch starts from the outer ring
  logic            first;
  logic [RP_W-1:0] cr, top_c, bot_c;
  logic [CP_W-1:0] cc, lft_c, rgt_c;
  logic [AW-1:0]   ix;
  dir_t            dir_c;

  assign first = (emit_count == '0);
  assign cr    = first ? '0 : cur_row;
  assign cc    = first ? '0 : cur_col;
  assign top_c = first ? '0 : top_bound;
  assign lft_c = first ? '0 : left_bound;
  assign bot_c = first ? RP_W'(r_eff - RS_W'(1)) : bottom_bound;
  assign rgt_c = first ? CP_W'(c_eff - CS_W'(1)) : right_bound;
  assign dir_c = first ? DIR_RIGHT : direction;
  assign ix    = first ? '0 : idx;

  // Step to the next spiral position, shrinking a bound at each corner
  logic [RP_W-1:0] cur_row_next, top_next, bottom_next;
  logic [CP_W-1:0] cur_col_next, left_next, right_next;
  logic [AW-1:0]   idx_next, c_step;
  dir_t            dir_next;

  assign c_step = AW'(c_eff);

  always_comb begin
    cur_row_next = cr;
    cur_col_next = cc;
    top_next     = top_c;
    bottom_next  = bot_c;
    left_next    = lft_c;
    right_next   = rgt_c;
    dir_next     = dir_c;
    idx_next     = ix;
    unique case (dir_c)
      DIR_RIGHT: begin
        if (cc < rgt_c) begin
          cur_col_next = cc + CP_W'(1);
          idx_next     = ix + AW'(1);
        end else begin
          top_next     = top_c + RP_W'(1);
          dir_next     = DIR_DOWN;
          cur_row_next = cr + RP_W'(1);
          idx_next     = ix + c_step;
        end
      end
      DIR_DOWN: begin
        if (cr < bot_c) begin
          cur_row_next = cr + RP_W'(1);
          idx_next     = ix + c_step;
        end else begin
          right_next   = rgt_c - CP_W'(1);
          dir_next     = DIR_LEFT;
          cur_col_next = cc - CP_W'(1);
          idx_next     = ix - AW'(1);
        end
      end
      DIR_LEFT: begin
        if (cc > lft_c) begin
          cur_col_next = cc - CP_W'(1);
          idx_next     = ix - AW'(1);
        end else begin
          bottom_next  = bot_c - RP_W'(1);
          dir_next     = DIR_UP;
          cur_row_next = cr - RP_W'(1);
          idx_next     = ix - c_step;
        end
      end
      DIR_UP: begin
        if (cr > top_c) begin
          cur_row_next = cr - RP_W'(1);
          idx_next     = ix - c_step;
        end else begin
          left_next    = lft_c + CP_W'(1);
          dir_next     = DIR_RIGHT;
          cur_col_next = cc + CP_W'(1);
          idx_next     = ix + AW'(1);
        end
      end
      default: begin
        dir_next = DIR_RIGHT;
      end
    endcase
  end

  logic [CNT_W-1:0] emit_next;
  logic             last_hit;

  assign emit_next = emit_count + CNT_W'(1);
  assign last_hit  = (emit_next == total);

  // Element store: loads write, fetches read; the read cycle stalls requests
  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  assign ram_we    = acc_load && load_ok;
  assign ram_addr  = acc_load ? load_base[AW-1:0] : ix;
  assign ram_wdata = DATA_WIDTH'($unsigned(req_data.value));

  sor_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Hold requests during the read cycle or while the result is stalled
  assign req_stall = (state == ST_READ) || (resp_valid && resp_stall);

  // Control state: configuration, load progress and spiral walk
  always_ff @(posedge clk) begin
    if (rst) begin
      rows         <= REG_W'(1);
      cols         <= REG_W'(1);
      load_count   <= '0;
      emit_count   <= '0;
      top_bound    <= '0;
      bottom_bound <= '0;
      left_bound   <= '0;
      right_bound  <= '0;
      cur_row      <= '0;
      cur_col      <= '0;
      idx          <= '0;
      direction    <= DIR_RIGHT;
      state        <= ST_IDLE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROWS: rows <= cfg_data;
          CFG_COLS: cols <= cfg_data;
          default: ;
        endcase
        load_count   <= '0;
        emit_count   <= '0;
        top_bound    <= '0;
        bottom_bound <= '0;
        left_bound   <= '0;
        right_bound  <= '0;
        cur_row      <= '0;
        cur_col      <= '0;
        idx          <= '0;
        direction    <= DIR_RIGHT;
      end else if (acc_load) begin
        // A load after a finished readout starts a new matrix
        if (done) begin
          emit_count   <= '0;
          top_bound    <= '0;
          bottom_bound <= '0;
          left_bound   <= '0;
          right_bound  <= '0;
          cur_row      <= '0;
          cur_col      <= '0;
          idx          <= '0;
          direction    <= DIR_RIGHT;
        end
        if (load_ok) begin
          load_count <= load_base + CNT_W'(1);
        end
      end else if (acc_fetch && fetch_ok) begin
        emit_count <= emit_next;
        if (!last_hit) begin
          top_bound    <= top_next;
          bottom_bound <= bottom_next;
          left_bound   <= left_next;
          right_bound  <= right_next;
          cur_row      <= cur_row_next;
          cur_col      <= cur_col_next;
          idx          <= idx_next;
          direction    <= dir_next;
        end else begin
          top_bound    <= top_c;
          bottom_bound <= bot_c;
          left_bound   <= lft_c;
          right_bound  <= rgt_c;
          cur_row      <= cr;
          cur_col      <= cc;
          idx          <= ix;
          direction    <= dir_c;
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (acc_fetch && fetch_ok) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Capture fetch metadata for the read cycle
  always_ff @(posedge clk) begin
    if (acc_fetch && fetch_ok) begin
      pend_row  <= cr;
      pend_col  <= cc;
      pend_last <= last_hit;
    end
  end

  // Result register: read data lands after the read cycle, errors at once
  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
    end else if (state == ST_READ) begin
      resp_valid <= 1'b1;
    end else if (acc_fetch && !fetch_ok) begin
      resp_valid <= 1'b1;
    end else if (resp_valid && !resp_stall) begin
      resp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      resp_data.elem_value <= VALUE_W'(ram_rdata);
      resp_data.row_pos    <= POS_W'(pend_row);
      resp_data.col_pos    <= POS_W'(pend_col);
      resp_data.is_last    <= pend_last;
      resp_data.error      <= 1'b0;
    end else if (acc_fetch && !fetch_ok) begin
      resp_data.elem_value <= '0;
      resp_data.row_pos    <= '0;
      resp_data.col_pos    <= '0;
      resp_data.is_last    <= 1'b0;
      resp_data.error      <= 1'b1;
    end
  end

endmodule

/* bench/sor_readout_checker.sv */
`timescale 1ns / 1ps
// Checker for the spiral order readout: tracks matrix loads and the spiral walk,
// predicts each fetch result and compares it with what the block returns.
// Depends on sor_pkg for the request, result and direction types.
module sor_readout_checker
  import sor_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_stall,
  input  req_t                 req_data,
  input  logic                 resp_valid,
  input  logic                 resp_stall,
  input  resp_t                resp_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   results_seen,
  output int                   refusals_seen
);

  // Size registers as written, and the predicted matrix contents
  logic [REG_W-1:0]   rows_reg;
  logic [REG_W-1:0]   cols_reg;
  logic [VALUE_W-1:0] elem_store [0:MAX_ROWS_DEF*MAX_COLS_DEF-1];

  // Load and readout progress, ring bounds and walk position
  int   loads_done;
  int   emitted;
  int   top_b;
  int   bottom_b;
  int   left_b;
  int   right_b;
  int   row_at;
  int   col_at;
  dir_t heading;

  resp_t results_due[$];

  // Map a size register to the size in use: zero acts as one, clamp at the maximum
  function automatic int eff_dim(input logic [REG_W-1:0] v, input int lim);
    if (v == '0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  // Clear load and readout progress
  task automatic restart_walk();
    loads_done = 0;
    emitted    = 0;
    top_b      = 0;
    bottom_b   = 0;
    left_b     = 0;
    right_b    = 0;
    heading    = DIR_RIGHT;
    row_at     = 0;
    col_at     = 0;
  endtask

  // Advance one spiral position, shrinking a bound at each corner
  task automatic step_walk();
    case (heading)
      DIR_RIGHT: begin
        if (col_at < right_b) begin
          col_at++;
        end else begin
          top_b++;
          heading = DIR_DOWN;
          row_at++;
        end
      end
      DIR_DOWN: begin
        if (row_at < bottom_b) begin
          row_at++;
        end else begin
          right_b--;
          heading = DIR_LEFT;
          col_at--;
        end
      end
      DIR_LEFT: begin
        if (col_at > left_b) begin
          col_at--;
        end else begin
          bottom_b--;
          heading = DIR_UP;
          row_at--;
        end
      end
      default: begin
        if (row_at > top_b) begin
          row_at--;
        end else begin
          left_b++;
          heading = DIR_RIGHT;
          col_at++;
        end
      end
    endcase
  endtask

  // Apply one accepted request; a fetch queues the result it must produce
  task automatic track_request(input req_t rq);
    int    r;
    int    c;
    int    total;
    resp_t res;
    r     = eff_dim(rows_reg, MAX_ROWS_DEF);
    c     = eff_dim(cols_reg, MAX_COLS_DEF);
    total = r * c;
    if (rq.mode == MODE_LOAD) begin
      // a load after a finished readout starts a new matrix
      if (emitted >= total) restart_walk();
      if (loads_done < total) begin
        elem_store[loads_done] = rq.value;
        loads_done++;
      end
    end else begin
      res = '0;
      if (loads_done < total || emitted >= total) begin
        res.error = 1'b1;
      end else begin
        if (emitted == 0) begin
          top_b    = 0;
          left_b   = 0;
          bottom_b = r - 1;
          right_b  = c - 1;
          heading  = DIR_RIGHT;
          row_at   = 0;
          col_at   = 0;
        end
        if (row_at >= 0 && col_at >= 0 && row_at < r && col_at < c)
          res.elem_value = elem_store[row_at * c + col_at];
        res.row_pos = row_at[POS_W-1:0];
        res.col_pos = col_at[POS_W-1:0];
        res.is_last = (emitted + 1 == total);
        emitted++;
        if (emitted < total) step_walk();
      end
      results_due.insert(results_due.size(), res);
    end
  endtask

  // Compare results first: a result never belongs to a request taken at the same edge
  always @(posedge clk) begin
    resp_t want;
    if (rst) begin
      rows_reg = 7'd1;
      cols_reg = 7'd1;
      restart_walk();
      results_due.delete();
    end else begin
      if (resp_valid && !resp_stall) begin
        results_seen++;
        if (resp_data.error) refusals_seen++;
        if (results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] unexpected result: value=%0d row=%0d col=%0d last=%0b err=%0b",
                     $time, resp_data.elem_value, resp_data.row_pos, resp_data.col_pos,
                     resp_data.is_last, resp_data.error);
        end else begin
          want = results_due.pop_front();
          if (resp_data.elem_value !== want.elem_value || resp_data.row_pos !== want.row_pos ||
              resp_data.col_pos !== want.col_pos || resp_data.is_last !== want.is_last ||
              resp_data.error !== want.error) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("[%0t] mismatch: expected value=%0d row=%0d col=%0d last=%0b err=%0b",
                       $time, want.elem_value, want.row_pos, want.col_pos, want.is_last,
                       want.error);
              $display("[%0t]           got      value=%0d row=%0d col=%0d last=%0b err=%0b",
                       $time, resp_data.elem_value, resp_data.row_pos,
                       resp_data.col_pos, resp_data.is_last, resp_data.error);
            end
          end
        end
      end
      // a size write restarts progress; stored data is kept
      if (cfg_we) begin
        if (cfg_index == CFG_ROWS) rows_reg = cfg_data;
        else cols_reg = cfg_data;
        restart_walk();
      end
      if (req_valid && !req_stall) track_request(req_data);
    end
    pending = results_due.size();
  end

endmodule

/* bench/spiral_order_readout_top_test.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for the spiral order readout block.
// Depends on sor_pkg, spiral_order_readout_top and sor_readout_checker.
module spiral_order_readout_top_test;
  import sor_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 1150;

  logic                 clk;
  logic                 rst;
  logic                 req_valid;
  logic                 req_stall;
  req_t                 req_data;
  logic                 resp_valid;
  logic                 resp_stall;
  resp_t                resp_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;

  int fail_count;
  int pending;
  int results_seen;
  int refusals_seen;

  // Stimulus bookkeeping
  bit               gaps_on;
  bit               stalls_on;
  int               sent_items;
  int               settings_used;
  logic [REG_W-1:0] rows_now;
  logic [REG_W-1:0] cols_now;

  spiral_order_readout_top uut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_data   (req_data),
    .resp_valid (resp_valid),
    .resp_stall (resp_stall),
    .resp_data  (resp_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  sor_readout_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req_data      (req_data),
    .resp_valid    (resp_valid),
    .resp_stall    (resp_stall),
    .resp_data     (resp_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen),
    .refusals_seen (refusals_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Size in use for a register value
  function automatic int eff_dim(input logic [REG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > 64) return 64;
    return int'(v);
  endfunction

  function automatic logic [REG_W-1:0] pick_big();
    case ($urandom_range(0, 2))
      0:       return 7'd64;
      1:       return 7'd127;
      default: return 7'($urandom_range(65, 126));
    endcase
  endfunction

  // Send one request after a random gap; hold it until accepted
  task automatic put_request(input logic m, input logic [VALUE_W-1:0] v);
    int gap;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid      <= 1'b1;
    req_data.mode  <= m;
    req_data.value <= v;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent_items++;
  endtask

  // Drop valid and wait until every result is back, plus time for a trailing load
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the size registers; only call while drained
  task automatic write_sizes(input logic [REG_W-1:0] rv, input logic [REG_W-1:0] cv,
                             input bit do_rows, input bit do_cols);
    if (do_rows) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_ROWS;
      cfg_data  <= rv;
      rows_now   = rv;
      @(posedge clk);
    end
    if (do_cols) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_COLS;
      cfg_data  <= cv;
      cols_now   = cv;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Load one matrix and read it out; a broken one stops the load early
  task automatic run_matrix(input int total, input bit broken);
    int n_loads;
    int n_fetch;
    n_loads = broken ? $urandom_range(0, total - 1) : total;
    for (int k = 0; k < n_loads; k++) begin
      if ($urandom_range(0, 19) == 0) put_request(MODE_FETCH, $urandom);
      put_request(MODE_LOAD, $urandom);
    end
    // loads past a full matrix are dropped
    if (!broken && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) put_request(MODE_LOAD, $urandom);
    if (broken) n_fetch = $urandom_range(1, 3);
    else n_fetch = total + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0);
    repeat (n_fetch) put_request(MODE_FETCH, $urandom);
  endtask

  // Receiver: random stall before each result
  initial begin
    int hold;
    resp_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold = stalls_on ? $urandom_range(0, 5) : 0;
      if (hold > 0) begin
        resp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        resp_stall <= 1'b0;
      end
      @(posedge clk);
      while (!resp_valid) @(posedge clk);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (resp_valid && !resp_stall) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [REG_W-1:0] rv;
    logic [REG_W-1:0] cv;
    int               which;
    rst        <= 1'b1;
    req_valid  <= 1'b0;
    req_data   <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_ROWS;
    cfg_data   <= '0;
    gaps_on    = 1'b1;
    stalls_on  = 1'b1;
    sent_items = 0;
    rows_now   = 7'd1;
    cols_now   = 7'd1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default 1x1: early fetch, full-load drop, last element, late fetch, reload
    put_request(MODE_FETCH, 32'h0);
    put_request(MODE_LOAD, 32'h8000_0000);
    put_request(MODE_LOAD, 32'h7FFF_FFFF);
    put_request(MODE_FETCH, 32'hFFFF_FFFF);
    put_request(MODE_FETCH, 32'h0);
    put_request(MODE_LOAD, 32'h7FFF_FFFF);
    put_request(MODE_FETCH, 32'h0);

    // 2x2 with an early fetch mid-load and a late fetch at the end
    drain();
    write_sizes(7'd2, 7'd2, 1'b1, 1'b1);
    put_request(MODE_LOAD, 32'hFFFF_FFFF);
    put_request(MODE_LOAD, 32'h0000_0000);
    put_request(MODE_FETCH, 32'h0);
    put_request(MODE_LOAD, 32'h5555_5555);
    put_request(MODE_LOAD, 32'hAAAA_AAAA);
    repeat (5) put_request(MODE_FETCH, 32'h0);

    // Size write in the middle of a load: progress restarts
    drain();
    write_sizes(7'd0, 7'd3, 1'b1, 1'b1);
    put_request(MODE_LOAD, 32'h1234_5678);
    put_request(MODE_LOAD, 32'h8765_4321);
    drain();
    write_sizes(7'd127, 7'd1, 1'b1, 1'b1);
    run_matrix(64, 1'b0);

    // Random phases of size settings, matrices, broken sequences and noise
    while (sent_items < RANDOM_ITEMS + 25) begin
      drain();
      case ($urandom_range(0, 7))
        0: begin rv = 7'd0; cv = 7'($urandom_range(1, 6)); end
        1: begin rv = 7'($urandom_range(1, 6)); cv = 7'd0; end
        2: begin rv = pick_big(); cv = 7'($urandom_range(1, 2)); end
        3: begin rv = 7'($urandom_range(1, 2)); cv = pick_big(); end
        default: begin rv = 7'($urandom_range(1, 6)); cv = 7'($urandom_range(1, 6)); end
      endcase
      // sometimes write one register only, when the other size is small
      which = $urandom_range(0, 3);
      if (which == 0 && eff_dim(cols_now) <= 6 && eff_dim(rv) <= 6)
        write_sizes(rv, cv, 1'b1, 1'b0);
      else if (which == 1 && eff_dim(rows_now) <= 6 && eff_dim(cv) <= 6)
        write_sizes(rv, cv, 1'b0, 1'b1);
      else
        write_sizes(rv, cv, 1'b1, 1'b1);
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 5) == 0)
          repeat ($urandom_range(1, 6)) put_request(1'($urandom_range(0, 1)), $urandom);
        run_matrix(eff_dim(rows_now) * eff_dim(cols_now), $urandom_range(0, 7) == 0);
        // hold the sender until the receiver has caught up
        if ($urandom_range(0, 4) == 0) drain();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d requests; checked %0d results, %0d of them refused fetches",
             sent_items, results_seen, refusals_seen);
    $display("Covered %0d size settings with random sender gaps and receiver stalls",
             settings_used);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/sor_pkg.sv
sv/sor_ram.sv
sv/spiral_order_readout_top.sv
bench/sor_readout_checker.sv
bench/spiral_order_readout_top_test.sv
